// ----- src/mif_pkg.sv -----
// Shared constants and types for the median image filter.
package mif_pkg;

  localparam int DEF_WINDOW   = 3;
  localparam int DEF_MAX_COLS = 1024;
  localparam int MAX_ROWS     = 4096;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 10;
  localparam int ROWS_W    = 13;
  localparam int COLS_W    = 11;
  localparam int CMP_W     = ROWS_W + 1;

  localparam logic [ROWS_W-1:0] RESET_ROWS = ROWS_W'(512);
  localparam logic [COLS_W-1:0] RESET_COLS = COLS_W'(512);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register word index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic median;  // pixel completes an interior window
    logic border;  // pixel lies on the border and passes through
  } emit_t;

endpackage

// ----- src/mif_line_bank.sv -----
// One line store bank: one row of pixels, registered read.
module mif_line_bank
  import mif_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  pixel_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output pixel_t                   rd_data
);

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/mif_median.sv -----
// Rank-select median of a full window, combinational.
module mif_median
  import mif_pkg::*;
#(
  parameter int N = 9
) (
  input  logic [N-1:0][PIX_W-1:0] values,
  output pixel_t                  median
);

  localparam int RANK_W = $clog2(N);

  logic [N-1:0][N-1:0] ahead;
  logic [N-1:0]        sel;

  // ahead[i][j]: element j sorts before element i (ties broken by index)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        if (j < i) begin
          ahead[i][j] = (values[j] <= values[i]);
        end else if (j > i) begin
          ahead[i][j] = (values[j] < values[i]);
        end else begin
          ahead[i][j] = 1'b0;
        end
      end
      sel[i] = (RANK_W'($countones(ahead[i])) == RANK_W'(N / 2));
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < N; i++) begin
      median = median | ({PIX_W{sel[i]}} & values[i]);
    end
  end

endmodule

// ----- src/mif_position.sv -----
// Raster position tracking, size clamping and border / window decisions.
module mif_position
  import mif_pkg::*;
#(
  parameter int WINDOW   = DEF_WINDOW,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ROWS_W-1:0]                 image_rows,
  input  logic [COLS_W-1:0]                 image_cols,
  input  logic                              advance,
  input  logic                              frame_start,
  output logic [ROW_W-1:0]                  row,
  output logic [$clog2(MAX_COLS)-1:0]       col,
  output logic [$clog2(WINDOW | 1)-1:0]     slot,
  output emit_t                             emit
);

  localparam int WIN    = WINDOW | 1;
  localparam int HALF   = WIN / 2;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int SLOT_W = $clog2(WIN);

  localparam logic [CMP_W-1:0] MIN_SIZE = CMP_W'(2 * WIN);
  localparam logic [CMP_W-1:0] LIM_ROWS = CMP_W'(MAX_ROWS);
  localparam logic [CMP_W-1:0] LIM_COLS = CMP_W'(MAX_COLS);
  localparam logic [CMP_W-1:0] HALF_V   = CMP_W'(HALF);
  localparam logic [CMP_W-1:0] SPAN_V   = CMP_W'(2 * HALF);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WIN - 1);

  logic [ROW_W-1:0]  row_count;
  logic [CNT_W-1:0]  col_count;   // may lie past a row width that shrank since
  logic [SLOT_W-1:0] slot_count;  // row_count mod WIN

  logic [ROW_W-1:0]  row_count_next;
  logic [CNT_W-1:0]  col_count_next;
  logic [SLOT_W-1:0] slot_count_next;

  logic [CMP_W-1:0]  rows_in, cols_in, rows_eff, cols_eff;
  logic [CMP_W-1:0]  r0, c0, r1, row_w, col_w, row_n, col_n;
  logic [SLOT_W-1:0] s0, s1;
  logic              wrap_c, wrap_r, wrap_end;

  always_comb begin
    rows_in  = CMP_W'(image_rows);
    cols_in  = CMP_W'(image_cols);
    rows_eff = (rows_in < MIN_SIZE) ? MIN_SIZE : ((rows_in > LIM_ROWS) ? LIM_ROWS : rows_in);
    cols_eff = (cols_in < MIN_SIZE) ? MIN_SIZE : ((cols_in > LIM_COLS) ? LIM_COLS : cols_in);

    r0 = frame_start ? '0 : CMP_W'(row_count);
    c0 = frame_start ? '0 : CMP_W'(col_count);
    s0 = frame_start ? '0 : slot_count;

    wrap_c = (c0 >= cols_eff);
    col_w  = wrap_c ? '0 : c0;
    r1     = wrap_c ? r0 + CMP_W'(1) : r0;
    if (wrap_c) begin
      s1 = (s0 == LAST_SLOT) ? '0 : s0 + SLOT_W'(1);
    end else begin
      s1 = s0;
    end

    wrap_r = (r1 >= rows_eff);
    row_w  = wrap_r ? '0 : r1;

    row  = ROW_W'(row_w);
    col  = COL_W'(col_w);
    slot = wrap_r ? '0 : s1;

    emit.median = (row_w >= SPAN_V) && (col_w >= SPAN_V);
    emit.border = (row_w < HALF_V) || (col_w < HALF_V) ||
                  (row_w + HALF_V >= rows_eff) || (col_w + HALF_V >= cols_eff);

    // end of row and end of frame wrap with the sizes in force for this beat
    col_n    = col_w + CMP_W'(1);
    row_n    = row_w + CMP_W'(1);
    wrap_end = (col_n >= cols_eff);
    if (!wrap_end) begin
      row_count_next  = ROW_W'(row_w);
      col_count_next  = CNT_W'(col_n);
      slot_count_next = slot;
    end else if (row_n >= rows_eff) begin
      row_count_next  = '0;
      col_count_next  = '0;
      slot_count_next = '0;
    end else begin
      row_count_next  = ROW_W'(row_n);
      col_count_next  = '0;
      slot_count_next = (slot == LAST_SLOT) ? '0 : slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      col_count  <= '0;
      slot_count <= '0;
    end else if (advance) begin
      row_count  <= row_count_next;
      col_count  <= col_count_next;
      slot_count <= slot_count_next;
    end
  end

endmodule

// ----- src/median_image_filter.sv -----
// Top level: streaming square-window median filter with APB size registers.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | pixel, frame_start
//  output   | out_valid / out_ready | out_row, out_col, out_value, last_of_run
//  config   | APB psel/penable      | image_rows @ 0x0, image_cols @ 0x4
//
// One pixel per cycle unless the output stalls. The first result beat
// passes through the line store read, the window register and the result
// register. A pixel giving two results (median plus border pass-through)
// keeps the output register busy for a second beat. Output stalls back up
// through the three stages; bubbles close up. Reset restores position,
// control and the size registers; the line store is not cleared.
module median_image_filter
  import mif_pkg::*;
#(
  parameter int WINDOW   = DEF_WINDOW,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROW_W-1:0]      out_row,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic [PIX_W-1:0]      out_value,
  output logic                  last_of_run
);

  localparam int WIN    = WINDOW | 1;
  localparam int HALF   = WIN / 2;
  localparam int N      = WIN * WIN;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int SLOT_W = $clog2(WIN);

  // configuration
  logic [ROWS_W-1:0] image_rows;
  logic [COLS_W-1:0] image_cols;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= RESET_ROWS;
      image_cols <= RESET_COLS;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ROWS: image_rows <= pwdata[ROWS_W-1:0];
        REG_COLS: image_cols <= pwdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS: prdata = APB_DATA_W'(image_rows);
      REG_COLS: prdata = APB_DATA_W'(image_cols);
      default:  prdata = '0;
    endcase
  end

  // pipeline control
  logic in_fire, s1_move, s2_move, s2_free, out_free, s2_has;
  logic s1_v, s2_v;

  assign out_free = !out_valid || (out_ready && last_of_run);
  assign s2_move  = s2_v && (out_free || !s2_has);
  assign s2_free  = !s2_v || s2_move;
  assign s1_move  = s1_v && s2_free;
  assign in_ready = !s1_v || s1_move;
  assign in_fire  = in_valid && in_ready;

  // position
  logic [ROW_W-1:0]  pos_row;
  logic [COL_W-1:0]  pos_col;
  logic [SLOT_W-1:0] pos_slot;
  emit_t             pos_emit;

  mif_position #(
    .WINDOW   (WINDOW),
    .MAX_COLS (MAX_COLS)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .image_rows  (image_rows),
    .image_cols  (image_cols),
    .advance     (in_fire),
    .frame_start (frame_start),
    .row         (pos_row),
    .col         (pos_col),
    .slot        (pos_slot),
    .emit        (pos_emit)
  );

  // line store: one bank per row slot, all read at the current column
  logic [WIN-1:0][PIX_W-1:0] bank_rd;

  for (genvar b = 0; b < WIN; b++) begin : g_bank
    mif_line_bank #(
      .DEPTH (MAX_COLS)
    ) u_bank (
      .clk     (clk),
      .wr_en   (in_fire && (pos_slot == SLOT_W'(b))),
      .wr_addr (pos_col),
      .wr_data (pixel),
      .rd_en   (in_fire),
      .rd_addr (pos_col),
      .rd_data (bank_rd[b])
    );
  end

  // stage 1: bank read in flight
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic [SLOT_W-1:0] s1_slot;
  pixel_t            s1_pixel;
  emit_t             s1_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_fire) begin
      s1_v <= 1'b1;
    end else if (s1_move) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row   <= pos_row;
      s1_col   <= pos_col;
      s1_slot  <= pos_slot;
      s1_pixel <= pixel;
      s1_emit  <= pos_emit;
    end
  end

  // stage 2: window shift register, newest column at index 0
  logic [N-1:0][PIX_W-1:0] win;
  logic [ROW_W-1:0]        s2_row;
  logic [COL_W-1:0]        s2_col;
  pixel_t                  s2_pixel;
  emit_t                   s2_emit;
  pixel_t                  med;

  assign s2_has = s2_emit.median || s2_emit.border;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s1_move) begin
      s2_v <= 1'b1;
    end else if (s2_move) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int b = 0; b < WIN; b++) begin
        // the current row's bank was read before this beat's write
        win[b] <= (s1_slot == SLOT_W'(b)) ? s1_pixel : bank_rd[b];
        for (int k = 1; k < WIN; k++) begin
          win[k * WIN + b] <= win[(k - 1) * WIN + b];
        end
      end
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_pixel <= s1_pixel;
      s2_emit  <= s1_emit;
    end
  end

  mif_median #(
    .N (N)
  ) u_median (
    .values (win),
    .median (med)
  );

  // output register: median beat first, then the border beat
  logic                 med_pend, bord_pend;
  logic [ROW_W-1:0]     o_med_row, o_row;
  logic [OUT_COL_W-1:0] o_med_col, o_col;
  pixel_t               o_med_val, o_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      med_pend  <= 1'b0;
      bord_pend <= 1'b0;
    end else if (s2_move && s2_has) begin
      out_valid <= 1'b1;
      med_pend  <= s2_emit.median;
      bord_pend <= s2_emit.border;
    end else if (out_valid && out_ready) begin
      if (last_of_run) begin
        out_valid <= 1'b0;
      end else begin
        med_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_has) begin
      o_med_row <= s2_row - ROW_W'(HALF);
      o_med_col <= OUT_COL_W'(s2_col - COL_W'(HALF));
      o_med_val <= med;
      o_row     <= s2_row;
      o_col     <= OUT_COL_W'(s2_col);
      o_pix     <= s2_pixel;
    end
  end

  assign out_row     = med_pend ? o_med_row : o_row;
  assign out_col     = med_pend ? o_med_col : o_col;
  assign out_value   = med_pend ? o_med_val : o_pix;
  assign last_of_run = !(med_pend && bord_pend);

  a_frame_origin: assert property (@(posedge clk) disable iff (rst)
    in_fire && frame_start |=> s1_row == '0 && s1_col == '0)
    else $error("frame start did not restart the position");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid && last_of_run && !med_pend)
    else $error("border beat did not follow the median beat");

  a_median_span: assert property (@(posedge clk) disable iff (rst)
    s2_v && s2_emit.median |-> s2_row >= ROW_W'(2 * HALF) && s2_col >= COL_W'(2 * HALF))
    else $error("median requested before the window is filled");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_v && !s1_move |=> s1_v && $stable(s1_col) && $stable(s1_slot))
    else $error("stalled stage 1 lost its beat");

  a_pend_valid: assert property (@(posedge clk) disable iff (rst)
    (med_pend || bord_pend) && !out_valid |=> !(s2_v && s2_has && !s2_move) || out_valid)
    else $error("output register dropped a pending result");

endmodule

// ----- tb/median_image_filter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the streaming 3x3 median image filter with APB size registers.
module median_image_filter_tb;
  import mif_pkg::*;

  localparam int     WIN           = 3;
  localparam int     HALF          = WIN / 2;
  localparam int     LINE_LEN      = DEF_MAX_COLS;
  localparam int     RANDOM_PIXELS = 200;
  localparam int     CALM_PIXELS   = 80;
  localparam int     SETTLE_CYCLES = 16;
  localparam longint CYCLE_LIMIT   = 6000000;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    pixel_t               value;
    logic                 last;
  } filtered_pixel_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  pixel_t                pixel       = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_col;
  pixel_t                out_value;
  logic                  last_of_run;

  // filter state as the block should hold it
  pixel_t            line_rows [WIN][LINE_LEN];
  int unsigned       row_pos  = 0;
  int unsigned       col_pos  = 0;
  logic [ROWS_W-1:0] rows_cfg = RESET_ROWS;
  logic [COLS_W-1:0] cols_cfg = RESET_COLS;
  filtered_pixel_t   expected_pixels [$];

  bit     idling_on   = 1'b1;
  bit     restart_due = 1'b0;
  int     stall_left  = 0;
  int     mismatches  = 0;
  longint cycles      = 0;

  median_image_filter dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[median_image_filter] ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  function automatic int unsigned active_rows();
    if (rows_cfg < 2 * WIN) return 2 * WIN;
    if (rows_cfg > MAX_ROWS) return MAX_ROWS;
    return rows_cfg;
  endfunction

  function automatic int unsigned active_cols();
    if (cols_cfg < 2 * WIN) return 2 * WIN;
    if (cols_cfg > DEF_MAX_COLS) return DEF_MAX_COLS;
    return cols_cfg;
  endfunction

  function automatic pixel_t window_median(input int unsigned r, input int unsigned c);
    pixel_t taps [WIN*WIN];
    pixel_t v;
    int     n, i, j, k;
    n = 0;
    for (j = 0; j < WIN; j++) begin
      for (i = 0; i < WIN; i++) begin
        taps[n] = line_rows[(r - 2 * HALF + i) % WIN][c - 2 * HALF + j];
        n++;
      end
    end
    for (i = 1; i < n; i++) begin
      v = taps[i];
      k = i;
      while (k > 0 && taps[k-1] > v) begin
        taps[k] = taps[k-1];
        k--;
      end
      taps[k] = v;
    end
    return taps[n / 2];
  endfunction

  function automatic void predict_pixel(input pixel_t pix, input logic fs);
    int unsigned     rows, cols, r, c;
    filtered_pixel_t found [2];
    int              n, k;
    rows = active_rows();
    cols = active_cols();
    n    = 0;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    // position may lie outside a size that shrank since the last pixel
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    r = row_pos;
    c = col_pos;
    line_rows[r % WIN][c] = pix;
    // completed window goes out ahead of this pixel's own pass-through
    if (r >= 2 * HALF && c >= 2 * HALF) begin
      found[n].row   = ROW_W'(r - HALF);
      found[n].col   = OUT_COL_W'(c - HALF);
      found[n].value = window_median(r, c);
      found[n].last  = 1'b0;
      n++;
    end
    if (r < HALF || c < HALF || r >= rows - HALF || c >= cols - HALF) begin
      found[n].row   = ROW_W'(r);
      found[n].col   = OUT_COL_W'(c);
      found[n].value = pix;
      found[n].last  = 1'b0;
      n++;
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (k = 0; k < n; k++) expected_pixels.insert(expected_pixels.size(), found[k]);
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
  endfunction

  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: check each beat, then pick the next ready level
  always @(posedge clk) begin : result_side
    filtered_pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch("beat with nothing pending, out_row", out_row, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (out_row !== want.row) flag_mismatch("out_row", out_row, want.row);
        if (out_col !== want.col) flag_mismatch("out_col", out_col, want.col);
        if (out_value !== want.value) flag_mismatch("out_value", out_value, want.value);
        if (last_of_run !== want.last) flag_mismatch("last_of_run", last_of_run, want.last);
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_pixel(input pixel_t pix, input logic fs);
    int   gap;
    logic fs_eff;
    fs_eff      = fs | restart_due;
    restart_due = 1'b0;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= pix;
    frame_start <= fs_eff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(pix, fs_eff);
  endtask

  task automatic stream_pixels(input int n, input bit mark_first);
    int k;
    for (k = 0; k < n; k++) send_pixel(pick_pixel(), mark_first && k == 0);
  endtask

  // wait out pending beats plus pixels that give no result
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_ROWS) rows_cfg = data[ROWS_W-1:0];
    else cols_cfg = data[COLS_W-1:0];
    @(posedge clk);
  endtask

  // Rows may change mid-frame, cols only shrink there; a wider line would
  // read store entries never written, so the next pixel starts a frame.
  task automatic resize(input int unsigned nrows, input int unsigned ncols);
    int unsigned           old_cols;
    logic [APB_DATA_W-1:0] junk;
    old_cols = active_cols();
    settle();
    junk = $urandom_range(0, 1) ? $urandom() : '0;
    write_reg(REG_ROWS, (junk << ROWS_W) | nrows);
    write_reg(REG_COLS, (junk << COLS_W) | ncols);
    if (active_cols() > old_cols && (row_pos != 0 || col_pos != 0)) restart_due = 1'b1;
  endtask

  task automatic test_reset_state();
    pixel_t seq [6];
    int     k;
    seq = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    for (k = 0; k < 6; k++) send_pixel(seq[k], 1'b0);
  endtask

  task automatic test_min_frame();
    int k;
    resize(6, 6);
    for (k = 0; k < 38; k++) begin
      case (k % 4)
        0: send_pixel('0, k == 0);
        1: send_pixel('1, 1'b0);
        default: send_pixel(pick_pixel(), 1'b0);
      endcase
    end
  endtask

  task automatic test_out_of_range();
    resize(0, 5);
    stream_pixels(40, 1'b1);
    resize(5, 0);
    stream_pixels(20, 1'b0);
    // widest line: runs past column 1023 into the next row
    resize(8191, 2047);
    stream_pixels(1030, 1'b1);
  endtask

  task automatic test_largest();
    resize(4096, 6);
    stream_pixels(40, 1'b1);
  endtask

  task automatic test_shrink_midframe();
    resize(12, 16);
    stream_pixels(87, 1'b1);
    resize(12, 6);   // column past the end: wraps to the next row
    stream_pixels(20, 1'b0);
    resize(7, 6);    // row past the end: wraps to row 0, column kept
    stream_pixels(50, 1'b0);
    resize(20, 6);
    stream_pixels(60, 1'b0);
    resize(20, 10);
    stream_pixels(40, 1'b0);
  endtask

  task automatic test_random_stream();
    int          sent, phase_len, k;
    int unsigned nrows, ncols;
    logic        fs;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      idling_on = (sent < RANDOM_PIXELS - CALM_PIXELS) ? ($urandom_range(0, 3) != 0) : 1'b0;
      case ($urandom_range(0, 19))
        0: nrows = $urandom_range(0, 5);
        1: nrows = $urandom_range(4097, 8191);
        2, 3: nrows = $urandom_range(15, 40);
        default: nrows = $urandom_range(6, 14);
      endcase
      case ($urandom_range(0, 19))
        0: ncols = $urandom_range(0, 5);
        1: ncols = $urandom_range(1025, 2047);
        2, 3: ncols = $urandom_range(25, 80);
        default: ncols = $urandom_range(6, 24);
      endcase
      resize(nrows, ncols);
      phase_len = active_rows() * active_cols();
      if (phase_len > 400) phase_len = $urandom_range(30, 400);
      else if ($urandom_range(0, 3) == 0) phase_len = $urandom_range(10, phase_len);
      for (k = 0; k < phase_len && sent < RANDOM_PIXELS; k++) begin
        if (sent == RANDOM_PIXELS - CALM_PIXELS) idling_on = 1'b0;
        if (row_pos == 0 && col_pos == 0) fs = $urandom_range(0, 1);
        else fs = ($urandom_range(0, 99) == 0);
        send_pixel(pick_pixel(), fs);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_min_frame();
    test_out_of_range();
    test_largest();
    test_shrink_midframe();
    test_random_stream();
    settle();
    if (mismatches == 0) begin
      $display("[median_image_filter] OK");
    end else begin
      $display("[median_image_filter] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mif_pkg.sv
src/mif_line_bank.sv
src/mif_median.sv
src/mif_position.sv
src/median_image_filter.sv
tb/median_image_filter_tb.sv
